// ===== rtl/ifld_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ifld_pkg
// Word types and opcode pattern constants for the instruction field and
// length decoder.
// ---------------------------------------------------------------------------
package ifld_pkg;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [7:0] fifth_byte;
        logic [7:0] sixth_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  matched_opcode;
        logic        direction_bit;
        logic        word_bit;
        logic        sign_bit;
        logic [1:0]  mod_field;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic        direct_address;
        logic [2:0]  instr_length;
        logic        unrecognized;
    } t_out_word;

    // opcode masks, tried in this order
    localparam logic [7:0] MASK_FF = 8'hff;
    localparam logic [7:0] MASK_FE = 8'hfe;
    localparam logic [7:0] MASK_FC = 8'hfc;
    localparam logic [7:0] MASK_F0 = 8'hf0;

    // opcode patterns
    localparam logic [7:0] OP_JCC_LO   = 8'h70;
    localparam logic [7:0] OP_JCC_HI   = 8'h7f;
    localparam logic [7:0] OP_LOOP_LO  = 8'he0;
    localparam logic [7:0] OP_LOOP_HI  = 8'he3;
    localparam logic [7:0] OP_MOV_SR_F = 8'h8c;
    localparam logic [7:0] OP_MOV_SR_T = 8'h8e;
    localparam logic [7:0] OP_MOV_RM   = 8'h88;
    localparam logic [7:0] OP_ADD_RM   = 8'h00;
    localparam logic [7:0] OP_SUB_RM   = 8'h28;
    localparam logic [7:0] OP_CMP_RM   = 8'h38;
    localparam logic [7:0] OP_MOV_IMR  = 8'hb0;
    localparam logic [7:0] OP_MOV_AM_L = 8'ha0;
    localparam logic [7:0] OP_MOV_AM_S = 8'ha2;
    localparam logic [7:0] OP_CMP_AI   = 8'h3c;
    localparam logic [7:0] OP_SUB_AI   = 8'h2c;
    localparam logic [7:0] OP_ADD_AI   = 8'h04;
    localparam logic [7:0] OP_GRP_C6   = 8'hc6;
    localparam logic [7:0] OP_GRP_80   = 8'h80;

    // mod/rm codes
    localparam logic [1:0] MOD_MEM0  = 2'd0;
    localparam logic [1:0] MOD_MEM8  = 2'd1;
    localparam logic [1:0] MOD_MEM16 = 2'd2;
    localparam logic [2:0] RM_DIRECT = 3'd6;

endpackage
`default_nettype wire

// ===== rtl/ifld_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ifld_stage
// One valid/stall register stage; takes a new word whenever it is empty or
// its word leaves in the same cycle.
// ---------------------------------------------------------------------------
module ifld_stage #(
    parameter int WIDTH = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_stall
);

    logic             r_valid;
    logic             n_valid;
    logic [WIDTH-1:0] r_data;

    assign o_stall = r_valid && i_stall;
    assign n_valid = o_stall ? 1'b1 : i_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ifld_decode.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ifld_decode
// Combinational decode of one six-byte window: pattern match, field
// extraction, displacement, immediate and length.
// ---------------------------------------------------------------------------
module ifld_decode (
    input  wire ifld_pkg::t_in_word i_word,
    output ifld_pkg::t_out_word     o_result
);

    function automatic logic is_pattern(input logic [7:0] v);
        logic hit;
        hit = ((v >= ifld_pkg::OP_JCC_LO) && (v <= ifld_pkg::OP_JCC_HI))
           || ((v >= ifld_pkg::OP_LOOP_LO) && (v <= ifld_pkg::OP_LOOP_HI))
           || (v == ifld_pkg::OP_MOV_SR_F) || (v == ifld_pkg::OP_MOV_SR_T)
           || (v == ifld_pkg::OP_MOV_RM)   || (v == ifld_pkg::OP_ADD_RM)
           || (v == ifld_pkg::OP_SUB_RM)   || (v == ifld_pkg::OP_CMP_RM)
           || (v == ifld_pkg::OP_MOV_IMR)  || (v == ifld_pkg::OP_MOV_AM_L)
           || (v == ifld_pkg::OP_MOV_AM_S) || (v == ifld_pkg::OP_CMP_AI)
           || (v == ifld_pkg::OP_SUB_AI)   || (v == ifld_pkg::OP_ADD_AI)
           || (v == ifld_pkg::OP_GRP_C6)   || (v == ifld_pkg::OP_GRP_80);
        return hit;
    endfunction

    logic [7:0] op;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] v_ff;
    logic [7:0] v_fe;
    logic [7:0] v_fc;
    logic [7:0] v_f0;
    logic [7:0] pat;
    logic       found;
    logic [1:0] m;
    logic [2:0] x;
    logic [1:0] nd;
    logic       two_imm;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;

    assign op = i_word.first_byte;
    assign b1 = i_word.second_byte;
    assign b2 = i_word.third_byte;
    assign b3 = i_word.fourth_byte;
    assign b4 = i_word.fifth_byte;
    assign b5 = i_word.sixth_byte;

    assign v_ff = op & ifld_pkg::MASK_FF;
    assign v_fe = op & ifld_pkg::MASK_FE;
    assign v_fc = op & ifld_pkg::MASK_FC;
    assign v_f0 = op & ifld_pkg::MASK_F0;

    assign m = b1[7:6];
    assign x = b1[2:0];

    // first mask in order that gives a known pattern wins
    always_comb begin
        found = 1'b1;
        if (is_pattern(v_ff)) begin
            pat = v_ff;
        end else if (is_pattern(v_fe)) begin
            pat = v_fe;
        end else if (is_pattern(v_fc)) begin
            pat = v_fc;
        end else if (is_pattern(v_f0)) begin
            pat = v_f0;
        end else begin
            pat   = 8'h00;
            found = 1'b0;
        end
    end

    // displacement bytes after the modrm byte
    always_comb begin
        case (m)
            ifld_pkg::MOD_MEM0:  nd = (x == ifld_pkg::RM_DIRECT) ? 2'd2 : 2'd0;
            ifld_pkg::MOD_MEM8:  nd = 2'd1;
            ifld_pkg::MOD_MEM16: nd = 2'd2;
            default:             nd = 2'd0;
        endcase
    end

    // group immediate sits right after the displacement
    always_comb begin
        case (nd)
            2'd1:    begin imm_lo = b3; imm_hi = b4; end
            2'd2:    begin imm_lo = b4; imm_hi = b5; end
            default: begin imm_lo = b2; imm_hi = b3; end
        endcase
    end

    always_comb begin
        two_imm  = 1'b0;
        o_result = '0;
        o_result.instr_length   = 3'd1;
        o_result.unrecognized   = !found;
        o_result.matched_opcode = pat;
        if (found) begin
            if (((pat >= ifld_pkg::OP_JCC_LO) && (pat <= ifld_pkg::OP_JCC_HI))
                || ((pat >= ifld_pkg::OP_LOOP_LO) && (pat <= ifld_pkg::OP_LOOP_HI))) begin
                o_result.immediate    = {8'h00, b1};
                o_result.instr_length = 3'd2;
            end else if ((pat == ifld_pkg::OP_MOV_SR_F)
                         || (pat == ifld_pkg::OP_MOV_SR_T)) begin
                o_result.reg_field    = {1'b0, b1[4:3]};
                o_result.mod_field    = m;
                o_result.rm_field     = x;
                o_result.instr_length = 3'd2 + {1'b0, nd};
            end else if ((pat == ifld_pkg::OP_MOV_RM) || (pat == ifld_pkg::OP_ADD_RM)
                         || (pat == ifld_pkg::OP_SUB_RM)
                         || (pat == ifld_pkg::OP_CMP_RM)) begin
                o_result.direction_bit = op[1];
                o_result.word_bit      = op[0];
                o_result.reg_field     = b1[5:3];
                o_result.mod_field     = m;
                o_result.rm_field      = x;
                o_result.instr_length  = 3'd2 + {1'b0, nd};
            end else if (pat == ifld_pkg::OP_MOV_IMR) begin
                o_result.word_bit     = op[3];
                o_result.reg_field    = op[2:0];
                o_result.immediate    = {(op[3] ? b2 : 8'h00), b1};
                o_result.instr_length = 3'd2 + {2'b00, op[3]};
            end else if ((pat == ifld_pkg::OP_MOV_AM_L)
                         || (pat == ifld_pkg::OP_MOV_AM_S)) begin
                o_result.word_bit     = op[0];
                o_result.displacement = {b2, b1};
                o_result.instr_length = 3'd3;
            end else if ((pat == ifld_pkg::OP_CMP_AI) || (pat == ifld_pkg::OP_SUB_AI)
                         || (pat == ifld_pkg::OP_ADD_AI)) begin
                o_result.word_bit     = op[0];
                o_result.immediate    = {(op[0] ? b2 : 8'h00), b1};
                o_result.instr_length = 3'd2 + {2'b00, op[0]};
            end else begin
                // immediate groups 80 and c6
                o_result.word_bit  = op[0];
                o_result.mod_field = m;
                o_result.rm_field  = x;
                if (pat == ifld_pkg::OP_GRP_80) begin
                    o_result.sign_bit  = op[1];
                    o_result.reg_field = b1[5:3];
                    two_imm            = op[0] && !op[1];
                end else begin
                    two_imm = op[0];
                end
                o_result.immediate    = {(two_imm ? imm_hi : 8'h00), imm_lo};
                o_result.instr_length = 3'd3 + {1'b0, nd} + {2'b00, two_imm};
            end

            // modrm forms share displacement and direct-address handling
            if ((pat == ifld_pkg::OP_MOV_SR_F) || (pat == ifld_pkg::OP_MOV_SR_T)
                || (pat == ifld_pkg::OP_MOV_RM) || (pat == ifld_pkg::OP_ADD_RM)
                || (pat == ifld_pkg::OP_SUB_RM) || (pat == ifld_pkg::OP_CMP_RM)
                || (pat == ifld_pkg::OP_GRP_80) || (pat == ifld_pkg::OP_GRP_C6)) begin
                o_result.displacement = {((nd == 2'd2) ? b3 : 8'h00),
                                         ((nd != 2'd0) ? b2 : 8'h00)};
                o_result.direct_address = (m == ifld_pkg::MOD_MEM0)
                                       && (x == ifld_pkg::RM_DIRECT);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/instr_field_length_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// instr_field_length_decoder
// An accepted window is held in the input register, decoded in a single
// shallow pass and its result word loaded into the result register.
// Throughput: one word per cycle while the output is not stalled.
// Reset clears both stage valid flags; no other state is kept.
// ---------------------------------------------------------------------------
module instr_field_length_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire ifld_pkg::t_in_word i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output ifld_pkg::t_out_word     o_out_data,
    input  wire logic               i_out_stall
);

    localparam int IN_W  = $bits(ifld_pkg::t_in_word);
    localparam int OUT_W = $bits(ifld_pkg::t_out_word);

    logic                 in_valid_q;
    logic                 mid_stall;
    logic [IN_W-1:0]      in_vec_q;
    ifld_pkg::t_in_word   in_word_q;
    ifld_pkg::t_out_word  dec_result;
    logic [OUT_W-1:0]     out_vec;

    ifld_stage #(
        .WIDTH (IN_W)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (IN_W'(i_in_data)),
        .o_stall (o_in_stall),
        .o_valid (in_valid_q),
        .o_data  (in_vec_q),
        .i_stall (mid_stall)
    );

    assign in_word_q = ifld_pkg::t_in_word'(in_vec_q);

    ifld_decode u_decode (
        .i_word   (in_word_q),
        .o_result (dec_result)
    );

    ifld_stage #(
        .WIDTH (OUT_W)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid_q),
        .i_data  (OUT_W'(dec_result)),
        .o_stall (mid_stall),
        .o_valid (o_out_valid),
        .o_data  (out_vec),
        .i_stall (i_out_stall)
    );

    assign o_out_data = ifld_pkg::t_out_word'(out_vec);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the instruction field and length decoder. A driver
// offers six-byte instruction windows from a queue and a monitor collects
// result words. Every accepted window is decoded by a local model, and each
// result word is compared field by field with the oldest pending decode.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block backs up and stalls its input.
// ---------------------------------------------------------------------------
module testbench;
    import ifld_pkg::*;

    localparam int unsigned WINDOW_COUNT  = 950;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned HOLD_AFTER    = 500;
    localparam int unsigned RUN_LIMIT     = 5000000;

    // opcode bit fields
    localparam logic [7:0] D_BIT      = 8'h02;
    localparam logic [7:0] S_BIT      = 8'h02;
    localparam logic [7:0] W_BIT      = 8'h01;
    localparam logic [7:0] IMR_W_BIT  = 8'h08;
    localparam logic [1:0] MOD_REG    = 2'd3;
    // matches no pattern under any mask
    localparam logic [7:0] OP_UNUSED  = 8'hf4;

    typedef struct {
        t_in_word    window;
        int unsigned gap_after;
    } t_pending_window;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_data;

    t_pending_window pending_windows[$];
    t_out_word       expected_decodes[$];
    t_pending_window next_window;
    t_out_word       oldest_decode;

    logic        in_taken      = 1'b0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    int unsigned stall_cycle   = 0;
    int unsigned results_seen  = 0;
    logic        hold_done     = 1'b0;
    int unsigned mismatch_count = 0;

    instr_field_length_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_opcode_pattern(logic [7:0] v);
        return (v >= OP_JCC_LO && v <= OP_JCC_HI) || (v >= OP_LOOP_LO && v <= OP_LOOP_HI) ||
               v inside {OP_MOV_SR_F, OP_MOV_SR_T, OP_MOV_RM, OP_ADD_RM, OP_SUB_RM,
                         OP_CMP_RM, OP_MOV_IMR, OP_MOV_AM_L, OP_MOV_AM_S, OP_CMP_AI,
                         OP_SUB_AI, OP_ADD_AI, OP_GRP_C6, OP_GRP_80};
    endfunction

    function automatic t_out_word decode_window(t_in_word win);
        logic [7:0]  b[6];
        logic [7:0]  masks[4];
        logic [7:0]  op;
        logic [7:0]  pat;
        logic [1:0]  m;
        logic [2:0]  r;
        logic [2:0]  x;
        bit          found;
        bit          has_modrm;
        bit          grp;
        int unsigned disp_len;
        int unsigned imm_len;
        int unsigned imm_pos;
        int unsigned len;
        t_out_word   o;
        b[0] = win.first_byte;
        b[1] = win.second_byte;
        b[2] = win.third_byte;
        b[3] = win.fourth_byte;
        b[4] = win.fifth_byte;
        b[5] = win.sixth_byte;
        masks[0] = MASK_FF;
        masks[1] = MASK_FE;
        masks[2] = MASK_FC;
        masks[3] = MASK_F0;
        op = b[0];
        pat = '0;
        found = 1'b0;
        has_modrm = 1'b0;
        grp = 1'b0;
        imm_len = 0;
        len = 1;
        o = '0;
        for (int i = 0; i < 4; i++) begin
            if (!found && is_opcode_pattern(op & masks[i])) begin
                pat = op & masks[i];
                found = 1'b1;
            end
        end
        m = b[1][7:6];
        r = b[1][5:3];
        x = b[1][2:0];
        if (m == MOD_MEM0) begin
            disp_len = (x == RM_DIRECT) ? 2 : 0;
        end else if (m == MOD_MEM8) begin
            disp_len = 1;
        end else if (m == MOD_MEM16) begin
            disp_len = 2;
        end else begin
            disp_len = 0;
        end
        if (found) begin
            if ((pat >= OP_JCC_LO && pat <= OP_JCC_HI) ||
                (pat >= OP_LOOP_LO && pat <= OP_LOOP_HI)) begin
                o.immediate = {8'h00, b[1]};
                len = 2;
            end else if (pat == OP_MOV_SR_F || pat == OP_MOV_SR_T) begin
                has_modrm = 1'b1;
                o.reg_field = {1'b0, r[1:0]};
            end else if (pat inside {OP_MOV_RM, OP_ADD_RM, OP_SUB_RM, OP_CMP_RM}) begin
                has_modrm = 1'b1;
                o.direction_bit = op[1];
                o.word_bit = op[0];
                o.reg_field = r;
            end else if (pat == OP_MOV_IMR) begin
                o.word_bit = op[3];
                o.reg_field = op[2:0];
                o.immediate = {op[3] ? b[2] : 8'h00, b[1]};
                len = op[3] ? 3 : 2;
            end else if (pat == OP_MOV_AM_L || pat == OP_MOV_AM_S) begin
                o.word_bit = op[0];
                o.displacement = {b[2], b[1]};
                len = 3;
            end else if (pat inside {OP_CMP_AI, OP_SUB_AI, OP_ADD_AI}) begin
                o.word_bit = op[0];
                o.immediate = {op[0] ? b[2] : 8'h00, b[1]};
                len = op[0] ? 3 : 2;
            end else begin
                // immediate groups: immediate follows modrm and displacement
                has_modrm = 1'b1;
                grp = 1'b1;
                o.word_bit = op[0];
                if (pat == OP_GRP_80) begin
                    o.sign_bit = op[1];
                    o.reg_field = r;
                    imm_len = (op[0] && !op[1]) ? 2 : 1;
                end else begin
                    imm_len = op[0] ? 2 : 1;
                end
                imm_pos = 2 + disp_len;
                o.immediate = {(imm_len == 2) ? b[imm_pos + 1] : 8'h00, b[imm_pos]};
            end
            if (has_modrm) begin
                o.mod_field = m;
                o.rm_field = x;
                if (disp_len >= 1) o.displacement[7:0] = b[2];
                if (disp_len == 2) o.displacement[15:8] = b[3];
                o.direct_address = (m == MOD_MEM0 && x == RM_DIRECT);
                len = 2 + disp_len + (grp ? imm_len : 0);
            end
        end
        o.matched_opcode = pat;
        o.instr_length = 3'(len);
        o.unrecognized = !found;
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic t_in_word make_window(logic [7:0] op, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3,
                                             logic [7:0] b4, logic [7:0] b5);
        return t_in_word'({op, b1, b2, b3, b4, b5});
    endfunction

    function automatic logic [7:0] modrm_byte(logic [1:0] m, logic [2:0] r, logic [2:0] x);
        return {m, r, x};
    endfunction

    function automatic t_in_word random_window();
        logic [7:0] rm_ops[4];
        logic [7:0] acc_ops[3];
        t_in_word   win;
        rm_ops[0] = OP_MOV_RM;
        rm_ops[1] = OP_ADD_RM;
        rm_ops[2] = OP_SUB_RM;
        rm_ops[3] = OP_CMP_RM;
        acc_ops[0] = OP_ADD_AI;
        acc_ops[1] = OP_SUB_AI;
        acc_ops[2] = OP_CMP_AI;
        win = t_in_word'({$urandom(), 16'($urandom())});
        case ($urandom_range(0, 12))
            0: win.first_byte = OP_JCC_LO | 8'($urandom_range(0, 15));
            1: win.first_byte = OP_LOOP_LO | 8'($urandom_range(0, 15));
            2: win.first_byte = $urandom_range(0, 1) ? OP_MOV_SR_F : OP_MOV_SR_T;
            3, 4: win.first_byte = rm_ops[$urandom_range(0, 3)] | 8'($urandom_range(0, 3));
            5: win.first_byte = OP_MOV_IMR | 8'($urandom_range(0, 15));
            6: win.first_byte = ($urandom_range(0, 1) ? OP_MOV_AM_L : OP_MOV_AM_S) |
                                8'($urandom_range(0, 1));
            7: win.first_byte = acc_ops[$urandom_range(0, 2)] | 8'($urandom_range(0, 1));
            8, 9: win.first_byte = OP_GRP_80 | 8'($urandom_range(0, 3));
            10: win.first_byte = OP_GRP_C6 | 8'($urandom_range(0, 1));
            default: ;
        endcase
        // steer some modrm bytes onto the direct address form
        if ($urandom_range(0, 4) == 0) begin
            win.second_byte = modrm_byte(MOD_MEM0, 3'($urandom_range(0, 7)), RM_DIRECT);
        end
        return win;
    endfunction

    task automatic queue_window(t_in_word win, int unsigned gap);
        t_pending_window pw;
        pw.window = win;
        pw.gap_after = gap;
        pending_windows.push_back(pw);
    endtask

    task automatic check_field(string field_name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field_name, want, got);
            mismatch_count++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_windows.size() != 0) begin
                next_window = pending_windows.pop_front();
                i_in_valid <= 1'b1;
                i_in_data <= next_window.window;
                gap_left <= next_window.gap_after;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            // long hold-off while the sender keeps offering
            i_out_stall <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            int unsigned len;
            len = pick_idle_length();
            if ((stall_cycle % 1000) < 200 || len == 0) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                stall_left <= len - 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_decodes.size() == 0) begin
                $error("result word with no window pending");
                mismatch_count++;
            end else begin
                oldest_decode = expected_decodes.pop_front();
                check_field("matched_opcode", oldest_decode.matched_opcode,
                            o_out_data.matched_opcode);
                check_field("direction_bit", oldest_decode.direction_bit,
                            o_out_data.direction_bit);
                check_field("word_bit", oldest_decode.word_bit, o_out_data.word_bit);
                check_field("sign_bit", oldest_decode.sign_bit, o_out_data.sign_bit);
                check_field("mod_field", oldest_decode.mod_field, o_out_data.mod_field);
                check_field("reg_field", oldest_decode.reg_field, o_out_data.reg_field);
                check_field("rm_field", oldest_decode.rm_field, o_out_data.rm_field);
                check_field("displacement", oldest_decode.displacement,
                            o_out_data.displacement);
                check_field("immediate", oldest_decode.immediate, o_out_data.immediate);
                check_field("direct_address", oldest_decode.direct_address,
                            o_out_data.direct_address);
                check_field("instr_length", oldest_decode.instr_length,
                            o_out_data.instr_length);
                check_field("unrecognized", oldest_decode.unrecognized,
                            o_out_data.unrecognized);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_decodes.push_back(decode_window(i_in_data));
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    initial begin
        // field extremes
        queue_window(make_window(OP_ADD_RM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        queue_window(make_window(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 0);
        // short jumps and loops, including opcodes that alias onto the loop range
        queue_window(make_window(OP_JCC_LO, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44), 1);
        queue_window(make_window(OP_JCC_HI, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 0);
        queue_window(make_window(OP_LOOP_HI, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff), 0);
        queue_window(make_window(OP_LOOP_LO | 8'h0c, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05), 2);
        // segment register moves
        queue_window(make_window(OP_MOV_SR_T, modrm_byte(MOD_MEM0, 3'd3, RM_DIRECT),
                                 8'h34, 8'h12, 8'hab, 8'hcd), 0);
        queue_window(make_window(OP_MOV_SR_F, modrm_byte(MOD_REG, 3'd7, 3'd5),
                                 8'hee, 8'hdd, 8'hcc, 8'hbb), 0);
        // register or memory forms over each memory mod
        queue_window(make_window(OP_MOV_RM | D_BIT | W_BIT, modrm_byte(MOD_MEM8, 3'd2, 3'd1),
                                 8'h80, 8'h7f, 8'h01, 8'h02), 0);
        queue_window(make_window(OP_ADD_RM | W_BIT, modrm_byte(MOD_MEM16, 3'd5, 3'd7),
                                 8'hfe, 8'hca, 8'h55, 8'haa), 3);
        queue_window(make_window(OP_SUB_RM | D_BIT, modrm_byte(MOD_MEM0, 3'd1, RM_DIRECT),
                                 8'h00, 8'h80, 8'h99, 8'h88), 0);
        queue_window(make_window(OP_CMP_RM, modrm_byte(MOD_MEM0, 3'd6, 3'd3),
                                 8'h12, 8'h34, 8'h56, 8'h78), 0);
        // immediate to register, byte and word
        queue_window(make_window(OP_MOV_IMR, 8'h55, 8'haa, 8'h00, 8'h00, 8'h00), 0);
        queue_window(make_window(OP_MOV_IMR | IMR_W_BIT | 8'h07, 8'hef, 8'hbe,
                                 8'h11, 8'h22, 8'h33), 5);
        // accumulator to and from memory
        queue_window(make_window(OP_MOV_AM_L | W_BIT, 8'h00, 8'hff, 8'h12, 8'h34, 8'h56), 0);
        queue_window(make_window(OP_MOV_AM_S, 8'hff, 8'h00, 8'h65, 8'h43, 8'h21), 0);
        // accumulator immediate
        queue_window(make_window(OP_ADD_AI, 8'h80, 8'h7f, 8'h00, 8'h00, 8'h00), 0);
        queue_window(make_window(OP_SUB_AI | W_BIT, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00), 0);
        queue_window(make_window(OP_CMP_AI | W_BIT, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00), 0);
        // immediate group with sign-extended and full word immediates
        queue_window(make_window(OP_GRP_80 | W_BIT, modrm_byte(MOD_MEM0, 3'd7, RM_DIRECT),
                                 8'h00, 8'h10, 8'hcd, 8'hab), 0);
        queue_window(make_window(OP_GRP_80 | S_BIT | W_BIT, modrm_byte(MOD_MEM8, 3'd5, 3'd0),
                                 8'hf0, 8'h81, 8'h77, 8'h66), 0);
        queue_window(make_window(OP_GRP_80, modrm_byte(MOD_REG, 3'd0, 3'd4),
                                 8'h99, 8'h44, 8'h33, 8'h22), 1);
        // move immediate group, register form takes its immediate too
        queue_window(make_window(OP_GRP_C6 | W_BIT, modrm_byte(MOD_REG, 3'd0, 3'd2),
                                 8'h34, 8'h12, 8'hff, 8'hff), 0);
        queue_window(make_window(OP_GRP_C6, modrm_byte(MOD_MEM16, 3'd3, RM_DIRECT),
                                 8'h00, 8'hff, 8'h5a, 8'ha5), 0);
        // no pattern matches
        queue_window(make_window(OP_UNUSED, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a), 0);

        for (int k = pending_windows.size(); k < WINDOW_COUNT; k++) begin
            // a stretch of back-to-back words in the middle
            queue_window(random_window(), (k >= 300 && k < 400) ? 0 : pick_idle_length());
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_windows.size() != 0 || i_in_valid || expected_decodes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
